// ===== rtl/core/ius_pkg.sv =====
// ---------------------------------------------------------------------------
// ius_pkg : shared constants for the image upsampler
// Field widths, code values and arithmetic widths of the blend datapath.
// ---------------------------------------------------------------------------
package ius_pkg;

    // pixel and coordinate fields
    localparam int PIX_BITS   = 16;
    localparam int COORD_W    = 10;
    localparam int MAX_SCALE  = 16;             // largest scale factor honored

    // stream word layout
    localparam int IN_TDATA_W  = 40;            // row, col, pixel, zero pad
    localparam int OUT_TDATA_W = 16;            // out_value

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 3'd4;

    localparam int SCALE_W = 5;                 // scale register width
    localparam int DIM_W   = 7;                 // in_height / in_width width

    // item kinds, result status, interpolation modes
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_RANGE     = 1'b1;
    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_BILIN   = 1'b1;

    // coordinate divide: numerator 2*o+1, divisor up to 2*MAX_SCALE
    localparam int CNW = COORD_W + 1;
    localparam int CDW = $clog2(2 * MAX_SCALE + 1);

    // blend: weight product, pixel product, four-tap sum
    localparam int WW = 2 * CDW;
    localparam int PW = PIX_BITS + WW + 1;
    localparam int SW = PW + 2;

endpackage

// ===== rtl/core/ius_div.sv =====
// ---------------------------------------------------------------------------
// ius_div : bit-serial restoring divider
// One quotient bit per cycle. The caller guarantees that the
// numerator is below den << QW, so only QW steps are needed.
// ---------------------------------------------------------------------------
module ius_div #(
    parameter int NW = 11,
    parameter int DW = 6,
    parameter int QW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    localparam int CW = $clog2(QW);

    logic [DW+NW-1:0] num_ext;
    logic [DW:0]      trial;
    logic             ge;
    logic [DW:0]      diff;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_q;
    logic [DW-1:0] r_den;

    assign num_ext = {{DW{1'b0}}, i_num};
    assign trial   = {r_rem, r_q[QW-1]};
    assign ge      = (trial >= {1'b0, r_den});
    assign diff    = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift numerator bits out the top of r_q, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num_ext[QW +: DW];
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/image_upsample_nearest_bilinear_top.sv =====
// ---------------------------------------------------------------------------
// image_upsample_nearest_bilinear_top : integer-factor image upscaler
// Holds one image plane in a single-port pixel store; load words fill it,
// query words return a nearest or half-pixel bilinear upscaled pixel.
// ---------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | word
//  ----------+-----------+----------------------------+-------------------------------
//  s_axis    | in        | tvalid/tready              | tuser: kind; tdata: row,col,pixel
//  m_axis    | out       | tvalid/tready              | tuser: status; tdata: out_value
//  cfg       | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
//  A load word is taken and written straight into the store unless it lies beyond it.
//  A query, in nearest and in bilinear mode, runs through these steps in order:
//  11 steps of the two coordinate dividers, one store read per tap (four
//  taps in bilinear, one in nearest) through the single store port, a drain
//  of the multiply-accumulate registers and 16 steps of the rounding divider.
//  An out-of-range query goes from idle straight to the finish state.
//  One item is in work at a time; the output register holds a finished word
//  while the next item is taken. Reset is synchronous, active low, and
//  clears control and configuration; the pixel store is not cleared.
//
module image_upsample_nearest_bilinear_top #(
    parameter int MAX_H = 64,
    parameter int MAX_W = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [ius_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // row[9:0] col[19:10] pixel[35:20]
    input  logic [0:0]                        i_s_axis_tuser,  // kind[0]
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [ius_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // out_value[15:0]
    output logic [0:0]                        o_m_axis_tuser,  // status[0]
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [ius_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ius_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int AW     = $clog2(MAX_H * MAX_W);
    localparam int DEPTH  = MAX_H * MAX_W;
    localparam int IH_CAP = (MAX_H < 127) ? MAX_H : 127;
    localparam int IW_CAP = (MAX_W < 127) ? MAX_W : 127;

    localparam int PB  = ius_pkg::PIX_BITS;
    localparam int CRD = ius_pkg::COORD_W;
    localparam int CNW = ius_pkg::CNW;
    localparam int CDW = ius_pkg::CDW;
    localparam int WW  = ius_pkg::WW;
    localparam int PW  = ius_pkg::PW;
    localparam int SW  = ius_pkg::SW;
    localparam int KW  = ius_pkg::SCALE_W;
    localparam int DMW = ius_pkg::DIM_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_READ  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_NORM  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // ---------------- configuration registers ----------------
    logic           r_mode;
    logic [KW-1:0]  r_scale_h;
    logic [KW-1:0]  r_scale_w;
    logic [DMW-1:0] r_in_height;
    logic [DMW-1:0] r_in_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ius_pkg::MODE_NEAREST;
            r_scale_h   <= KW'(2);
            r_scale_w   <= KW'(2);
            r_in_height <= DMW'(64);
            r_in_width  <= DMW'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ius_pkg::CFG_MODE:      r_mode      <= i_cfg_wdata[0];
                ius_pkg::CFG_SCALE_H:   r_scale_h   <= i_cfg_wdata[KW-1:0];
                ius_pkg::CFG_SCALE_W:   r_scale_w   <= i_cfg_wdata[KW-1:0];
                ius_pkg::CFG_IN_HEIGHT: r_in_height <= i_cfg_wdata[DMW-1:0];
                ius_pkg::CFG_IN_WIDTH:  r_in_width  <= i_cfg_wdata[DMW-1:0];
                default: ;  // unused indexes drop the write
            endcase
        end
    end

    // effective settings: zero acts as one, oversize values saturate
    logic [KW-1:0]  kh, kw;
    logic [DMW-1:0] ih, iw, ih_m1, iw_m1;

    assign kh = (r_scale_h == '0) ? KW'(1) :
                (r_scale_h > KW'(ius_pkg::MAX_SCALE)) ? KW'(ius_pkg::MAX_SCALE) : r_scale_h;
    assign kw = (r_scale_w == '0) ? KW'(1) :
                (r_scale_w > KW'(ius_pkg::MAX_SCALE)) ? KW'(ius_pkg::MAX_SCALE) : r_scale_w;
    assign ih = (r_in_height == '0) ? DMW'(1) :
                (r_in_height > DMW'(IH_CAP)) ? DMW'(IH_CAP) : r_in_height;
    assign iw = (r_in_width == '0) ? DMW'(1) :
                (r_in_width > DMW'(IW_CAP)) ? DMW'(IW_CAP) : r_in_width;
    assign ih_m1 = ih - DMW'(1);
    assign iw_m1 = iw - DMW'(1);

    // ---------------- input word unpack ----------------
    logic           in_kind;
    logic [CRD-1:0] in_row, in_col;
    logic [PB-1:0]  in_pix;

    assign in_kind = i_s_axis_tuser[0];
    assign in_row  = i_s_axis_tdata[CRD-1:0];
    assign in_col  = i_s_axis_tdata[2*CRD-1:CRD];
    assign in_pix  = i_s_axis_tdata[2*CRD +: PB];

    // ---------------- control ----------------
    t_state r_state, n_state;
    logic   s_acc, q_acc, q_oor, q_start;
    logic [DMW+KW-1:0] lim_h, lim_w;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign q_acc   = s_acc && (in_kind == ius_pkg::KIND_QUERY);
    assign lim_h   = (DMW+KW)'(ih) * (DMW+KW)'(kh);
    assign lim_w   = (DMW+KW)'(iw) * (DMW+KW)'(kw);
    assign q_oor   = ((DMW+KW)'(in_row) >= lim_h) || ((DMW+KW)'(in_col) >= lim_w);
    assign q_start = q_acc && !q_oor;

    // ---------------- coordinate dividers ----------------
    // nearest: o / k ; bilinear: max(2o+1-k, 0) / 2k with remainder
    logic [CNW-1:0] odd_r, odd_c, num_r, num_c;
    logic [CDW-1:0] dh, dw, den_r, den_c;
    logic           row_done, col_done;
    logic [CNW-1:0] row_q, col_q;
    logic [CDW-1:0] row_f, col_f;

    assign dh    = {kh, 1'b0};
    assign dw    = {kw, 1'b0};
    assign odd_r = {in_row, 1'b1};
    assign odd_c = {in_col, 1'b1};

    always_comb begin
        if (r_mode == ius_pkg::MODE_BILIN) begin
            num_r = (odd_r > CNW'(kh)) ? odd_r - CNW'(kh) : '0;
            num_c = (odd_c > CNW'(kw)) ? odd_c - CNW'(kw) : '0;
            den_r = dh;
            den_c = dw;
        end else begin
            num_r = CNW'(in_row);
            num_c = CNW'(in_col);
            den_r = CDW'(kh);
            den_c = CDW'(kw);
        end
    end

    ius_div #(.NW(CNW), .DW(CDW), .QW(CNW)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_num   (num_r),
        .i_den   (den_r),
        .o_done  (row_done),
        .o_quo   (row_q),
        .o_rem   (row_f)
    );

    ius_div #(.NW(CNW), .DW(CDW), .QW(CNW)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_num   (num_c),
        .i_den   (den_c),
        .o_done  (col_done),
        .o_quo   (col_q),
        .o_rem   (col_f)
    );

    // clamp source coordinates to the plane in use, pick neighbors and weights
    logic [DMW-1:0] y0, x0, y1, x1;
    logic [CDW-1:0] wy0, wy1, wx0, wx1;
    logic [WW-1:0]  den_all;

    assign y0 = (row_q > CNW'(ih_m1)) ? ih_m1 : row_q[DMW-1:0];
    assign x0 = (col_q > CNW'(iw_m1)) ? iw_m1 : col_q[DMW-1:0];
    assign y1 = ({1'b0, y0} + 1'b1 < {1'b0, ih}) ? y0 + DMW'(1) : ih_m1;
    assign x1 = ({1'b0, x0} + 1'b1 < {1'b0, iw}) ? x0 + DMW'(1) : iw_m1;

    always_comb begin
        if (r_mode == ius_pkg::MODE_BILIN) begin
            wy0     = dh - row_f;
            wy1     = row_f;
            wx0     = dw - col_f;
            wx1     = col_f;
            den_all = WW'(dh) * WW'(dw);
        end else begin
            // single tap with unit weight, unit divisor
            wy0     = CDW'(1);
            wy1     = '0;
            wx0     = CDW'(1);
            wx1     = '0;
            den_all = WW'(1);
        end
    end

    logic [DMW-1:0] r_y0, r_y1, r_x0, r_x1;
    logic [CDW-1:0] r_wy0, r_wy1, r_wx0, r_wx1;
    logic [WW-1:0]  r_den;

    // ---------------- pixel store ----------------
    logic [PB-1:0]  mem [DEPTH];
    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_addr, ld_addr, rd_addr;
    logic [DMW-1:0] tap_y, tap_x;
    logic [PB-1:0]  r_rd;
    logic [1:0]     r_tap;
    logic [1:0]     last_tap;

    assign mem_we   = s_acc && (in_kind == ius_pkg::KIND_LOAD)
                      && (int'(in_row) < MAX_H) && (int'(in_col) < MAX_W);
    assign mem_re   = (r_state == S_READ);
    assign tap_y    = r_tap[1] ? r_y1 : r_y0;
    assign tap_x    = r_tap[0] ? r_x1 : r_x0;
    assign ld_addr  = AW'(in_row) * AW'(MAX_W) + AW'(in_col);
    assign rd_addr  = AW'(tap_y) * AW'(MAX_W) + AW'(tap_x);
    assign mem_addr = mem_re ? rd_addr : ld_addr;
    assign last_tap = (r_mode == ius_pkg::MODE_BILIN) ? 2'd3 : 2'd0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= in_pix;
        end
        if (mem_re) begin
            r_rd <= mem[mem_addr];
        end
    end

    // ---------------- blend accumulate ----------------
    logic [CDW-1:0]        tap_wy, tap_wx;
    logic [WW-1:0]         r_wgt;
    logic signed [PW-1:0]  r_prod;
    logic signed [SW-1:0]  r_sum;
    logic                  r_v1, r_v2;
    logic                  drained, nrm_start, nrm_done;
    logic [SW-1:0]         mag, nrm_num;
    logic [PB-1:0]         nrm_q;
    logic [WW-1:0]         nrm_r;
    logic                  r_neg, r_oor;

    assign tap_wy = r_tap[1] ? r_wy1 : r_wy0;
    assign tap_wx = r_tap[0] ? r_wx1 : r_wx0;

    // round half away from zero: (|sum| + den/2) / den, sign restored after
    assign drained   = !r_v1 && !r_v2;
    assign nrm_start = (r_state == S_DRAIN) && drained;
    assign mag       = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign nrm_num   = mag + SW'(r_den >> 1);

    ius_div #(.NW(SW), .DW(WW), .QW(PB)) u_div_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nrm_start),
        .i_num   (nrm_num),
        .i_den   (r_den),
        .o_done  (nrm_done),
        .o_quo   (nrm_q),
        .o_rem   (nrm_r)
    );

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (q_acc) n_state = q_oor ? S_FIN : S_DIV;
            S_DIV:   if (row_done) n_state = S_READ;
            S_READ:  if (r_tap == last_tap) n_state = S_DRAIN;
            S_DRAIN: if (drained) n_state = S_NORM;
            S_NORM:  if (nrm_done) n_state = S_FIN;
            S_FIN:   if (!o_m_axis_tvalid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic fin_load;
    logic r_m_valid;
    logic [PB-1:0] r_m_data;
    logic          r_m_user;
    logic [PB-1:0] res_val;

    assign fin_load = (r_state == S_FIN) && (!r_m_valid || i_m_axis_tready);
    assign res_val  = r_oor ? '0 : (r_neg ? PB'(-nrm_q) : nrm_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tap     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= mem_re;
            r_v2    <= r_v1;
            r_tap   <= mem_re ? r_tap + 2'd1 : 2'd0;
            // hold the result word until taken; reload behind a taken word
            if (fin_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_acc) begin
            r_oor <= q_oor;
        end
        if (r_state == S_DIV && row_done) begin
            r_y0  <= y0;
            r_y1  <= y1;
            r_x0  <= x0;
            r_x1  <= x1;
            r_wy0 <= wy0;
            r_wy1 <= wy1;
            r_wx0 <= wx0;
            r_wx1 <= wx1;
            r_den <= den_all;
        end
        if (mem_re) begin
            r_wgt <= WW'(tap_wy) * WW'(tap_wx);
        end
        if (r_v1) begin
            r_prod <= $signed(r_rd) * $signed({1'b0, r_wgt});
        end
        if (q_start) begin
            r_sum <= '0;
        end else if (r_v2) begin
            r_sum <= r_sum + SW'(r_prod);
        end
        if (nrm_start) begin
            r_neg <= r_sum[SW-1];
        end
        if (fin_load) begin
            r_m_data <= res_val;
            r_m_user <= r_oor ? ius_pkg::ST_RANGE : ius_pkg::ST_OK;
        end
    end

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = r_m_data;
    assign o_m_axis_tuser[0] = r_m_user;

    // ---------------- assertions ----------------
    // the single store port never serves a load and a tap read together
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store written and read in the same cycle");

    // both coordinate dividers run in lockstep
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_done == col_done)
        else $error("row and column dividers out of step");

    // a new result word only appears out of the finish state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_FIN))
        else $error("result word raised outside the finish state");

    // an out-of-range answer carries a zero value
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0] == ius_pkg::ST_RANGE)
            |-> (o_m_axis_tdata == '0))
        else $error("out-of-range result with nonzero value");

    // the rounding divider leaves a remainder below its divisor
    a_nrm_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nrm_done |-> (nrm_r < r_den))
        else $error("blend divider remainder not below divisor");

endmodule

// ===== tb/tb_image_upsample_nearest_bilinear_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_image_upsample_nearest_bilinear_top : self-checking bench for the upscaler
// Primes the whole pixel plane, then runs directed and random load/query words
// under a series of register settings, predicting every query result from a
// private copy of the plane and comparing it with the output stream.
// ---------------------------------------------------------------------------
module tb_image_upsample_nearest_bilinear_top;

    import ius_pkg::*;

    localparam int PLANE_H      = 64;
    localparam int PLANE_W      = 64;
    localparam int PRIME_WORDS  = PLANE_H * PLANE_W;
    localparam int IDLE_PCT     = 36;
    localparam int DRAIN_CYCLES = 48;          // longest query latency plus margin
    localparam int CALM_LO      = PRIME_WORDS + 350;
    localparam int CALM_HI      = PRIME_WORDS + 500;
    localparam int HOLD_AT      = 120;         // results seen before the long hold
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic                kind;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [PIX_BITS-1:0] pix;
    } pixel_op_t;

    typedef struct {
        logic [PIX_BITS-1:0] value;
        logic                status;
    } upscaled_t;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // row[9:0] col[19:10] pixel[35:20]
    logic [0:0]             i_s_axis_tuser = '0;   // kind[0]
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // out_value[15:0]
    logic [0:0]             o_m_axis_tuser;        // status[0]
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    image_upsample_nearest_bilinear_top #(
        .MAX_H (PLANE_H),
        .MAX_W (PLANE_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state: shadow registers, shadow plane, queues and counters
    // ------------------------------------------------------------------
    logic                       mode_r = MODE_NEAREST;
    logic [SCALE_W-1:0]         scale_h_r = 5'd2;
    logic [SCALE_W-1:0]         scale_w_r = 5'd2;
    logic [DIM_W-1:0]           in_h_r = 7'd64;
    logic [DIM_W-1:0]           in_w_r = 7'd64;
    logic signed [PIX_BITS-1:0] plane_ref [0:PRIME_WORDS-1];

    pixel_op_t pixel_ops_q[$];     // words waiting for the input stream
    upscaled_t upscaled_q[$];      // query results still owed by the block

    int n_pushed   = 0;            // words queued for the input stream
    int n_issued   = 0;            // words put on the input stream
    int n_in_acc   = 0;            // words taken by the block
    int n_out_acc  = 0;            // results taken from the block
    int n_fail     = 0;
    int n_loads    = 0;
    int n_queries  = 0;
    int n_range    = 0;
    int n_bilin    = 0;
    int n_settings = 1;
    int hold_left  = 0;
    bit hold_used  = 1'b0;

    function automatic int eff_scale(input int v);
        if (v < 1) return 1;
        if (v > MAX_SCALE) return MAX_SCALE;
        return v;
    endfunction

    function automatic int eff_dim(input int v, input int lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic bit in_calm();
        return n_in_acc >= CALM_LO && n_in_acc < CALM_HI;
    endfunction

    // Half-pixel source position: integer part and numerator over 2k,
    // clamped at zero.
    function automatic void half_pixel(input int o, input int k,
                                       output int ip, output int fr);
        int n;
        n  = (2 * o + 1 > k) ? 2 * o + 1 - k : 0;
        ip = n / (2 * k);
        fr = n % (2 * k);
    endfunction

    // Expected answer of one query under the current shadow registers.
    function automatic upscaled_t upscale(input int row, input int col);
        upscaled_t res;
        int        kh, kw, ih, iw, y0, x0, y1, x1, fy, fx;
        longint    p00, p01, p10, p11, lo_r, hi_r, sum, den, mag, q;
        kh = eff_scale(scale_h_r);
        kw = eff_scale(scale_w_r);
        ih = eff_dim(in_h_r, PLANE_H);
        iw = eff_dim(in_w_r, PLANE_W);
        res.value  = '0;
        res.status = ST_OK;
        if (row >= ih * kh || col >= iw * kw) begin
            res.status = ST_RANGE;
            return res;
        end
        if (mode_r == MODE_NEAREST) begin
            res.value = plane_ref[(row / kh) * PLANE_W + col / kw];
            return res;
        end
        half_pixel(row, kh, y0, fy);
        half_pixel(col, kw, x0, fx);
        if (y0 > ih - 1) y0 = ih - 1;
        if (x0 > iw - 1) x0 = iw - 1;
        // clamp the far neighbours to the last row and column
        y1   = (y0 + 1 < ih) ? y0 + 1 : ih - 1;
        x1   = (x0 + 1 < iw) ? x0 + 1 : iw - 1;
        p00  = plane_ref[y0 * PLANE_W + x0];
        p01  = plane_ref[y0 * PLANE_W + x1];
        p10  = plane_ref[y1 * PLANE_W + x0];
        p11  = plane_ref[y1 * PLANE_W + x1];
        lo_r = longint'(2 * kw - fx) * p00 + longint'(fx) * p01;
        hi_r = longint'(2 * kw - fx) * p10 + longint'(fx) * p11;
        sum  = longint'(2 * kh - fy) * lo_r + longint'(fy) * hi_r;
        den  = longint'(4 * kw * kh);
        // round to nearest, ties away from zero
        mag  = (sum < 0) ? -sum : sum;
        q    = (mag + den / 2) / den;
        res.value = (sum < 0) ? -q : q;
        return res;
    endfunction

    // Apply one accepted word to the shadow plane or queue its answer.
    function automatic void take_word(input logic kind, input int row, input int col,
                                      input logic [PIX_BITS-1:0] pix);
        upscaled_t res;
        if (kind == KIND_LOAD) begin
            n_loads++;
            if (row < PLANE_H && col < PLANE_W)
                plane_ref[row * PLANE_W + col] = pix;
        end else begin
            n_queries++;
            res = upscale(row, col);
            if (res.status == ST_RANGE) n_range++;
            else if (mode_r == MODE_BILIN) n_bilin++;
            upscaled_q.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: present queued words at the falling edge, hold a word
    // until the monitor has seen it taken, idle at random between words
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && n_in_acc < n_issued) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (pixel_ops_q.size() != 0 &&
                     (in_calm() || $urandom_range(99) >= IDLE_PCT)) begin
            pixel_op_t op;
            op = pixel_ops_q.pop_front();
            i_s_axis_tdata  <= {4'b0, op.pix, op.col, op.row};
            i_s_axis_tuser  <= op.kind;
            i_s_axis_tvalid <= 1'b1;
            n_issued++;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, one long hold once enough results have
    // come back so the block backs up and stalls its input
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_used && n_out_acc >= HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= in_calm() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both streams at the rising edge, predict on input
    // acceptance, compare on output acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                take_word(i_s_axis_tuser[0], i_s_axis_tdata[9:0],
                          i_s_axis_tdata[19:10], i_s_axis_tdata[35:20]);
                n_in_acc++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                upscaled_t want;
                n_out_acc++;
                if (upscaled_q.size() == 0) begin
                    $error("result with nothing expected: out_value %0d status %0d",
                           $signed(o_m_axis_tdata), o_m_axis_tuser[0]);
                    n_fail++;
                end else begin
                    want = upscaled_q.pop_front();
                    if (o_m_axis_tdata !== want.value) begin
                        $error("out_value mismatch: expected %0d, actual %0d",
                               $signed(want.value), $signed(o_m_axis_tdata));
                        n_fail++;
                    end
                    if (o_m_axis_tuser[0] !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_m_axis_tuser[0]);
                        n_fail++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic push_op(input logic kind, input int row, input int col, input int pix);
        pixel_op_t op;
        op.kind = kind;
        op.row  = row[COORD_W-1:0];
        op.col  = col[COORD_W-1:0];
        op.pix  = pix[PIX_BITS-1:0];
        pixel_ops_q.push_back(op);
        n_pushed++;
    endtask

    // Pick an output coordinate: mostly inside the output, some on its edge,
    // some anywhere in the field.
    function automatic int pick_coord(input int span);
        int r;
        r = $urandom_range(99);
        if (r < 10) return (span > 1023) ? 1023 : span - ($urandom_range(1) == 0 ? 1 : 0);
        if (r < 22) return $urandom_range(1023);
        return $urandom_range((span > 1024 ? 1024 : span) - 1);
    endfunction

    task automatic queue_random(input int n);
        int oh, ow;
        oh = eff_dim(in_h_r, PLANE_H) * eff_scale(scale_h_r);
        ow = eff_dim(in_w_r, PLANE_W) * eff_scale(scale_w_r);
        repeat (n) begin
            if ($urandom_range(99) < 30) begin
                // loads: mostly inside the store, some beyond it
                push_op(KIND_LOAD,
                        ($urandom_range(99) < 85) ? $urandom_range(PLANE_H - 1)
                                                  : $urandom_range(1023),
                        ($urandom_range(99) < 85) ? $urandom_range(PLANE_W - 1)
                                                  : $urandom_range(1023),
                        $urandom_range(16'hFFFF));
            end else begin
                push_op(KIND_QUERY, pick_coord(oh), pick_coord(ow), $urandom_range(16'hFFFF));
            end
        end
    endtask

    // Hold until every word is taken and every result is back, then let
    // any trailing load settle before touching the registers.
    task automatic drain();
        while (n_in_acc != n_pushed || upscaled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_MODE:      mode_r    = val[0];
            CFG_SCALE_H:   scale_h_r = val[SCALE_W-1:0];
            CFG_SCALE_W:   scale_w_r = val[SCALE_W-1:0];
            CFG_IN_HEIGHT: in_h_r    = val[DIM_W-1:0];
            CFG_IN_WIDTH:  in_w_r    = val[DIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_setting(input int m, input int kh, input int kw,
                               input int ih, input int iw, input int n);
        write_reg(CFG_MODE, m);
        write_reg(CFG_SCALE_H, kh);
        write_reg(CFG_SCALE_W, kw);
        write_reg(CFG_IN_HEIGHT, ih);
        write_reg(CFG_IN_WIDTH, iw);
        n_settings++;
        queue_random(n);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Prime every pixel so no query ever reads an unwritten entry.
        for (int r = 0; r < PLANE_H; r++)
            for (int c = 0; c < PLANE_W; c++)
                push_op(KIND_LOAD, r, c, $urandom_range(16'hFFFF));

        // Directed words at the reset settings (nearest, 2x2, full plane):
        // extreme pixels in the corners, loads beyond the store, queries on
        // and just past the output edges.
        push_op(KIND_LOAD, 0, 0, 16'h7FFF);
        push_op(KIND_LOAD, 63, 63, 16'h8000);
        push_op(KIND_LOAD, 0, 63, 16'hFFFF);
        push_op(KIND_LOAD, 63, 0, 16'h0000);
        push_op(KIND_LOAD, 64, 0, 16'h1234);
        push_op(KIND_LOAD, 0, 64, 16'h4321);
        push_op(KIND_LOAD, 1023, 1023, 16'hAAAA);
        push_op(KIND_QUERY, 0, 0, 16'h5555);
        push_op(KIND_QUERY, 1, 1, 0);
        push_op(KIND_QUERY, 127, 127, 0);
        push_op(KIND_QUERY, 0, 127, 0);
        push_op(KIND_QUERY, 127, 0, 0);
        push_op(KIND_QUERY, 128, 0, 0);
        push_op(KIND_QUERY, 0, 128, 0);
        push_op(KIND_QUERY, 1023, 1023, 16'hFFFF);
        push_op(KIND_QUERY, 1023, 0, 0);
        queue_random(100);
        drain();

        // Register sweep: bilinear and nearest at several sizes, the largest and smallest
        // factors and dimensions, out-of-range register values, odd shapes.
        run_setting(MODE_BILIN,   2,  2,  64, 64, 110);
        run_setting(MODE_BILIN,  16, 16,  64, 64,  90);
        run_setting(MODE_BILIN,   1,  1,   1,  1,  70);
        run_setting(MODE_BILIN,   0, 31,   0, 127, 80);
        run_setting(MODE_NEAREST, 3,  5,   7, 13,  90);
        run_setting(MODE_BILIN,   7,  3,  33,  2, 100);
        run_setting(MODE_NEAREST, 16, 1,  64, 64,  70);
        run_setting(MODE_BILIN,   5,  9,  64,  1,  80);
        repeat (2)
            run_setting($urandom_range(1), $urandom_range(31), $urandom_range(31),
                        $urandom_range(127), $urandom_range(127), 60);

        if (upscaled_q.size() != 0) begin
            $error("%0d expected results never arrived", upscaled_q.size());
            n_fail++;
        end
        $display("Covered %0d loads and %0d queries (%0d bilinear, %0d out of range)",
                 n_loads, n_queries, n_bilin, n_range);
        $display("over %0d register settings with random stalls on both streams",
                 n_settings);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $error("run timed out with %0d words taken and %0d results owed",
               n_in_acc, upscaled_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ius_pkg.sv
rtl/core/ius_div.sv
rtl/core/image_upsample_nearest_bilinear_top.sv
tb/tb_image_upsample_nearest_bilinear_top.sv
